FILE: hw/rtl/fpm_pkg.sv
// Shared types and constants for the FIFO pair matcher.
// Holds the control word, the status flags and the field widths that fpm_idx, fpm_seq and the top level use.
// No dependencies.
`default_nettype none

package fpm_pkg;

    // Fixed field widths
    localparam int ID_W      = 10;
    localparam int ACT_W     = 2;
    localparam int ST_W      = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Parameter defaults
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_COUNT_DEF    = 1024;

    typedef enum logic [ST_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_MATCHED  = 2'd1,
        ST_NOMATCH  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        IDX_CMD = 1'b0,
        IDX_RQ  = 1'b1
    } idx_src_t;

    // Datapath half of a control word
    typedef struct packed {
        logic     accept;
        logic     clr;
        idx_src_t idx_src;
        logic     bm_rd;
        logic     bm_wr;
        logic     bm_val;
        logic     rq_push;
        logic     rq_rd;
        logic     rq_pop;
        logic     pv_push;
        logic     pv_rd;
        logic     pv_pop;
        logic     emit;
        status_t  st;
    } ctrl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic             in_valid;
        logic [ACT_W-1:0] action;
        logic             clr_busy;
        logic             out_free;
        logic             rq_full;
        logic             pv_full;
        logic             rq_empty;
        logic             pv_empty;
        logic             bit_set;
    } flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for both queues and the waiting bitmap.
`default_nettype none

module fpm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fpm_idx.sv
// Waiting-bit index unit: id mod ID_COUNT in two registered stages.
// Uses fpm_pkg for the id width.
`default_nettype none

module fpm_idx
    import fpm_pkg::*;
#(
    parameter int ID_COUNT = ID_COUNT_DEF
) (
    input  wire logic                        clk,
    input  wire logic [ID_W-1:0]             id,
    output logic      [$clog2(ID_COUNT)-1:0] idx
);

    localparam int IDX_W = $clog2(ID_COUNT);

    generate
        if (ID_COUNT >= (1 << ID_W))
        begin : g_direct
            logic [ID_W-1:0] id1_reg;

            always_ff @(posedge clk)
            begin
                id1_reg <= id;
                idx     <= IDX_W'(id1_reg);
            end
        end
        else
        begin : g_recip
            // Exact quotient for any id below 2**ID_W
            localparam int K     = 2 * ID_W;
            localparam int RECIP = ((1 << K) + ID_COUNT - 1) / ID_COUNT;

            logic [K-1:0]      recip_c;
            logic [K+ID_W-1:0] prod_reg;
            logic [ID_W-1:0]   id1_reg;
            logic [ID_W-1:0]   quot;
            logic [2*ID_W-1:0] back;
            logic [ID_W-1:0]   rem;

            assign recip_c = K'(RECIP);
            assign quot    = prod_reg[K+ID_W-1:K];
            assign back    = (2*ID_W)'(quot) * (2*ID_W)'(ID_COUNT);
            assign rem     = id1_reg - back[ID_W-1:0];

            always_ff @(posedge clk)
            begin
                prod_reg <= {{K{1'b0}}, id} * {{ID_W{1'b0}}, recip_c};
                id1_reg  <= id;
                idx      <= rem[IDX_W-1:0];
            end
        end
    endgenerate

endmodule

`default_nettype wire

FILE: hw/rtl/fpm_seq.sv
// Microcode sequencer: step counter, control ROM and jump logic.
// Uses fpm_pkg for the control word and the flag struct.
`default_nettype none

module fpm_seq
    import fpm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire flags_t flags,
    output ctrl_t       ctrl
);

    typedef enum logic [4:0] {
        S_CLR       = 5'd0,
        S_FETCH     = 5'd1,
        S_DISP      = 5'd2,
        S_RQ_CHK    = 5'd3,   // dispatch table, two steps per action
        S_RQ_PUSH   = 5'd4,
        S_PV_CHK    = 5'd5,
        S_PV_PUSH   = 5'd6,
        S_MT_HEAD   = 5'd7,
        S_MT_IDX0   = 5'd8,
        S_CN_WAIT   = 5'd9,
        S_CN_CLR    = 5'd10,
        S_MT_IDX1   = 5'd11,
        S_MT_BMRD   = 5'd12,
        S_MT_TEST   = 5'd13,
        S_MT_SKIP   = 5'd14,
        S_MT_PVCHK  = 5'd15,
        S_MT_POP    = 5'd16,
        S_EM_ACC    = 5'd17,
        S_EM_FULL   = 5'd18,
        S_EM_NOM    = 5'd19,
        S_EM_MATCH  = 5'd20
    } step_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_CLR_BUSY,
        C_IN_VALID,
        C_OUT_FREE,
        C_DISPATCH,
        C_RQ_FULL,
        C_PV_FULL,
        C_RQ_EMPTY,
        C_PV_EMPTY,
        C_BIT_SET
    } cond_t;

    // hold: stay on the step until the condition is met, ops fire on leaving
    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        logic  hold;
        step_t target;
    } uword_t;

    function automatic uword_t ucode(step_t s);
        uword_t w;
        w        = '0;
        w.cond   = C_ALWAYS;
        w.target = S_FETCH;
        case (s)
            S_CLR:
            begin
                w.ctrl.clr = 1'b1;
                w.cond     = C_CLR_BUSY;
                w.target   = S_CLR;
            end
            S_FETCH:
            begin
                w.ctrl.accept = 1'b1;
                w.cond        = C_IN_VALID;
                w.hold        = 1'b1;
                w.target      = S_DISP;
            end
            S_DISP:
            begin
                w.cond   = C_DISPATCH;
                w.target = S_RQ_CHK;
            end
            S_RQ_CHK:
            begin
                w.cond   = C_RQ_FULL;
                w.target = S_EM_FULL;
            end
            S_RQ_PUSH:
            begin
                w.ctrl.rq_push = 1'b1;
                w.ctrl.bm_wr   = 1'b1;
                w.ctrl.bm_val  = 1'b1;
                w.target       = S_EM_ACC;
            end
            S_PV_CHK:
            begin
                w.cond   = C_PV_FULL;
                w.target = S_EM_FULL;
            end
            S_PV_PUSH:
            begin
                w.ctrl.pv_push = 1'b1;
                w.target       = S_EM_ACC;
            end
            S_MT_HEAD:
            begin
                w.ctrl.idx_src = IDX_RQ;
                w.ctrl.rq_rd   = 1'b1;
                w.cond         = C_RQ_EMPTY;
                w.target       = S_EM_NOM;
            end
            S_MT_IDX0:
            begin
                w.ctrl.idx_src = IDX_RQ;
                w.target       = S_MT_IDX1;
            end
            S_CN_WAIT:
            begin
                w.target = S_CN_CLR;
            end
            S_CN_CLR:
            begin
                w.ctrl.bm_wr = 1'b1;
                w.target     = S_EM_ACC;
            end
            S_MT_IDX1:
            begin
                w.ctrl.idx_src = IDX_RQ;
                w.target       = S_MT_BMRD;
            end
            S_MT_BMRD:
            begin
                w.ctrl.idx_src = IDX_RQ;
                w.ctrl.bm_rd   = 1'b1;
                w.target       = S_MT_TEST;
            end
            S_MT_TEST:
            begin
                w.ctrl.idx_src = IDX_RQ;
                w.cond         = C_BIT_SET;
                w.target       = S_MT_PVCHK;
            end
            S_MT_SKIP:
            begin
                w.ctrl.idx_src = IDX_RQ;
                w.ctrl.rq_pop  = 1'b1;
                w.target       = S_MT_HEAD;
            end
            S_MT_PVCHK:
            begin
                w.ctrl.idx_src = IDX_RQ;
                w.cond         = C_PV_EMPTY;
                w.target       = S_EM_NOM;
            end
            S_MT_POP:
            begin
                w.ctrl.idx_src = IDX_RQ;
                w.ctrl.rq_pop  = 1'b1;
                w.ctrl.pv_rd   = 1'b1;
                w.ctrl.pv_pop  = 1'b1;
                w.ctrl.bm_wr   = 1'b1;
                w.target       = S_EM_MATCH;
            end
            S_EM_ACC:
            begin
                w.ctrl.emit = 1'b1;
                w.ctrl.st   = ST_ACCEPTED;
                w.cond      = C_OUT_FREE;
                w.hold      = 1'b1;
            end
            S_EM_FULL:
            begin
                w.ctrl.emit = 1'b1;
                w.ctrl.st   = ST_FULL;
                w.cond      = C_OUT_FREE;
                w.hold      = 1'b1;
            end
            S_EM_NOM:
            begin
                w.ctrl.emit = 1'b1;
                w.ctrl.st   = ST_NOMATCH;
                w.cond      = C_OUT_FREE;
                w.hold      = 1'b1;
            end
            S_EM_MATCH:
            begin
                w.ctrl.emit = 1'b1;
                w.ctrl.st   = ST_MATCHED;
                w.cond      = C_OUT_FREE;
                w.hold      = 1'b1;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_FETCH;
            end
        endcase
        return w;
    endfunction

    step_t  upc_reg;
    step_t  upc_next;
    uword_t word;
    logic   taken;
    logic   fire;

    assign word = ucode(upc_reg);

    always_comb
    begin
        case (word.cond)
            C_ALWAYS:   taken = 1'b1;
            C_CLR_BUSY: taken = flags.clr_busy;
            C_IN_VALID: taken = flags.in_valid;
            C_OUT_FREE: taken = flags.out_free;
            C_DISPATCH: taken = 1'b1;
            C_RQ_FULL:  taken = flags.rq_full;
            C_PV_FULL:  taken = flags.pv_full;
            C_RQ_EMPTY: taken = flags.rq_empty;
            C_PV_EMPTY: taken = flags.pv_empty;
            C_BIT_SET:  taken = flags.bit_set;
            default:    taken = 1'b1;
        endcase
    end

    assign fire = !word.hold || taken;

    always_comb
    begin
        if (word.cond == C_DISPATCH)
        begin
            upc_next = step_t'(word.target + {2'b00, flags.action, 1'b0});
        end
        else if (taken)
        begin
            upc_next = word.target;
        end
        else if (word.hold)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = step_t'(upc_reg + 5'd1);
        end
    end

    // Drop every side effect of a held step until it leaves
    always_comb
    begin
        ctrl = word.ctrl;
        if (!fire)
        begin
            ctrl.clr     = 1'b0;
            ctrl.bm_rd   = 1'b0;
            ctrl.bm_wr   = 1'b0;
            ctrl.rq_push = 1'b0;
            ctrl.rq_rd   = 1'b0;
            ctrl.rq_pop  = 1'b0;
            ctrl.pv_push = 1'b0;
            ctrl.pv_rd   = 1'b0;
            ctrl.pv_pop  = 1'b0;
            ctrl.emit    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_CLR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fifo_pair_matcher_with_cancel.sv
// Top level of the FIFO pair matcher with lazy cancel: datapath, queues and bitmap.
// Depends on fpm_pkg, fpm_ram, fpm_idx and fpm_seq.
`default_nettype none

// Channel  Dir  Fields (low bit up)                        Beat taken when
// s_*      in   tuser: action[1:0]; tdata: id[9:0]        s_tvalid && s_tready
// m_*      out  tuser: status[1:0]; tdata: provider_id     m_tvalid && m_tready
//               [9:0], requester_id[19:10]
//
// After reset a clearing pass writes the waiting bitmap, one bit a cycle, over all
// ID_COUNT bits; s_tready stays low until it ends.
// An add requester or add provider on a full queue gives a full result. Match
// looks up the waiting bit of each requester head (RAM read, two-stage index
// unit, RAM read) and pops a head whose bit is clear; with no match it stops
// when the requester queue runs empty, or at a live head when the provider
// queue is empty.
// One command is in work at a time. The output register holds a result while
// m_tready is low and the next command is taken meanwhile; it stalls only at
// its own result step.
module fifo_pair_matcher_with_cancel
    import fpm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_COUNT    = ID_COUNT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // id[9:0], zero fill
    input  wire logic [ACT_W-1:0]     s_tuser,   // action[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // provider_id[9:0], requester_id[19:10]
    output logic      [ST_W-1:0]      m_tuser    // status[1:0]
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(ID_COUNT);

    ctrl_t  ctrl;
    flags_t flags;

    // Latched command
    logic [ACT_W-1:0] cmd_action_reg;
    logic [ID_W-1:0]  cmd_id_reg;

    // Queue pointers and fill counts
    logic [PTR_W-1:0] rq_head_reg, rq_head_next;
    logic [PTR_W-1:0] rq_tail_reg, rq_tail_next;
    logic [CNT_W-1:0] rq_count_reg, rq_count_next;
    logic [PTR_W-1:0] pv_head_reg, pv_head_next;
    logic [PTR_W-1:0] pv_tail_reg, pv_tail_next;
    logic [CNT_W-1:0] pv_count_reg, pv_count_next;

    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;

    // Output register
    logic             m_valid_reg, m_valid_next;
    status_t          m_status_reg;
    logic [ID_W-1:0]  m_pid_reg;
    logic [ID_W-1:0]  m_rid_reg;

    logic [ID_W-1:0]  rq_rdata;
    logic [ID_W-1:0]  pv_rdata;
    logic [ID_W-1:0]  idx_id;
    logic [IDX_W-1:0] idx;
    logic             bm_wr_en;
    logic [IDX_W-1:0] bm_wr_addr;
    logic [0:0]       bm_wr_data;
    logic [0:0]       bm_rdata;
    logic             in_beat;
    logic             out_free;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    fpm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign s_tready = ctrl.accept;
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign flags.in_valid = s_tvalid;
    assign flags.action   = cmd_action_reg;
    assign flags.clr_busy = (clr_cnt_reg != IDX_W'(ID_COUNT - 1));
    assign flags.out_free = out_free;
    assign flags.rq_full  = (rq_count_reg == CNT_W'(QUEUE_DEPTH));
    assign flags.pv_full  = (pv_count_reg == CNT_W'(QUEUE_DEPTH));
    assign flags.rq_empty = (rq_count_reg == '0);
    assign flags.pv_empty = (pv_count_reg == '0);
    assign flags.bit_set  = bm_rdata[0];

    // Latch the command on the input beat
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cmd_action_reg <= s_tuser;
            cmd_id_reg     <= s_tdata[ID_W-1:0];
        end
    end

    // Index the bitmap by the command id or by the requester head
    assign idx_id = (ctrl.idx_src == IDX_RQ) ? rq_rdata : cmd_id_reg;

    fpm_idx #(
        .ID_COUNT (ID_COUNT)
    ) u_idx (
        .clk (clk),
        .id  (idx_id),
        .idx (idx)
    );

    assign bm_wr_en   = ctrl.bm_wr || ctrl.clr;
    assign bm_wr_addr = ctrl.clr ? clr_cnt_reg : idx;
    assign bm_wr_data = ctrl.clr ? 1'b0 : ctrl.bm_val;

    fpm_ram #(
        .WIDTH (1),
        .DEPTH (ID_COUNT)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (bm_wr_en),
        .wr_addr (bm_wr_addr),
        .wr_data (bm_wr_data),
        .rd_en   (ctrl.bm_rd),
        .rd_addr (idx),
        .rd_data (bm_rdata)
    );

    fpm_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_rq_fifo (
        .clk     (clk),
        .wr_en   (ctrl.rq_push),
        .wr_addr (rq_tail_reg),
        .wr_data (cmd_id_reg),
        .rd_en   (ctrl.rq_rd),
        .rd_addr (rq_head_reg),
        .rd_data (rq_rdata)
    );

    fpm_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_pv_fifo (
        .clk     (clk),
        .wr_en   (ctrl.pv_push),
        .wr_addr (pv_tail_reg),
        .wr_data (cmd_id_reg),
        .rd_en   (ctrl.pv_rd),
        .rd_addr (pv_head_reg),
        .rd_data (pv_rdata)
    );

    // Advance pointers and counts; a push and a pop never share a step
    always_comb
    begin
        rq_head_next  = ctrl.rq_pop  ? ptr_inc(rq_head_reg) : rq_head_reg;
        rq_tail_next  = ctrl.rq_push ? ptr_inc(rq_tail_reg) : rq_tail_reg;
        pv_head_next  = ctrl.pv_pop  ? ptr_inc(pv_head_reg) : pv_head_reg;
        pv_tail_next  = ctrl.pv_push ? ptr_inc(pv_tail_reg) : pv_tail_reg;
        rq_count_next = rq_count_reg;
        if (ctrl.rq_push)
        begin
            rq_count_next = rq_count_reg + 1'b1;
        end
        else if (ctrl.rq_pop)
        begin
            rq_count_next = rq_count_reg - 1'b1;
        end
        pv_count_next = pv_count_reg;
        if (ctrl.pv_push)
        begin
            pv_count_next = pv_count_reg + 1'b1;
        end
        else if (ctrl.pv_pop)
        begin
            pv_count_next = pv_count_reg - 1'b1;
        end
        clr_cnt_next = ctrl.clr ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    end

    // Load the output register on emit, drop it on the output beat
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (ctrl.emit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_head_reg  <= '0;
            rq_tail_reg  <= '0;
            rq_count_reg <= '0;
            pv_head_reg  <= '0;
            pv_tail_reg  <= '0;
            pv_count_reg <= '0;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            rq_head_reg  <= rq_head_next;
            rq_tail_reg  <= rq_tail_next;
            rq_count_reg <= rq_count_next;
            pv_head_reg  <= pv_head_next;
            pv_tail_reg  <= pv_tail_next;
            pv_count_reg <= pv_count_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Ids go out only with a match; the queue read data still holds both heads
    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            m_status_reg <= ctrl.st;
            if (ctrl.st == ST_MATCHED)
            begin
                m_pid_reg <= pv_rdata;
                m_rid_reg <= rq_rdata;
            end
            else
            begin
                m_pid_reg <= '0;
                m_rid_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*ID_W){1'b0}}, m_rid_reg, m_pid_reg};

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for the FIFO pair matcher with lazy cancel.
// Drives commands on the s_* stream, checks m_* results against an in-bench predictor.
// Depends on fpm_pkg and fifo_pair_matcher_with_cancel.
`timescale 1ns / 100ps

module tb;
    import fpm_pkg::*;

    // Command codes carried in s_tuser
    localparam logic [ACT_W-1:0] ACT_ADD_REQUESTER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_PROVIDER  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MATCH         = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CANCEL        = 2'd3;

    localparam int QUEUE_SLOTS = QUEUE_DEPTH_DEF;
    localparam int BITMAP_SIZE = ID_COUNT_DEF;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        status_t         status;
        logic [ID_W-1:0] provider_id;
        logic [ID_W-1:0] requester_id;
    } match_outcome_t;

    // Predicts the matcher and compares every result beat with the oldest prediction.
    class pair_match_scoreboard;
        logic [ID_W-1:0] requester_line[$];
        logic [ID_W-1:0] provider_line[$];
        bit              waiting_bits[BITMAP_SIZE];
        match_outcome_t  expected_outcomes[$];
        int              errors;

        function void note_command(logic [ACT_W-1:0] act, logic [ID_W-1:0] id);
            match_outcome_t o;
            o.status       = ST_ACCEPTED;
            o.provider_id  = '0;
            o.requester_id = '0;
            case (act)
                ACT_ADD_REQUESTER:
                    if (requester_line.size() >= QUEUE_SLOTS)
                        o.status = ST_FULL;
                    else
                    begin
                        requester_line.push_back(id);
                        waiting_bits[int'(id) % BITMAP_SIZE] = 1'b1;
                    end
                ACT_ADD_PROVIDER:
                    if (provider_line.size() >= QUEUE_SLOTS)
                        o.status = ST_FULL;
                    else
                        provider_line.push_back(id);
                ACT_MATCH:
                begin
                    // drop cancelled heads first
                    while (requester_line.size() > 0 &&
                           !waiting_bits[int'(requester_line[0]) % BITMAP_SIZE])
                        void'(requester_line.pop_front());
                    if (requester_line.size() == 0 || provider_line.size() == 0)
                        o.status = ST_NOMATCH;
                    else
                    begin
                        o.status       = ST_MATCHED;
                        o.requester_id = requester_line.pop_front();
                        o.provider_id  = provider_line.pop_front();
                        waiting_bits[int'(o.requester_id) % BITMAP_SIZE] = 1'b0;
                    end
                end
                default:
                    waiting_bits[int'(id) % BITMAP_SIZE] = 1'b0;
            endcase
            expected_outcomes.push_back(o);
        endfunction

        function void check_outcome(status_t st, logic [ID_W-1:0] pid, logic [ID_W-1:0] rid);
            match_outcome_t want;
            if (expected_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with none expected: status %0d provider %0d requester %0d",
                         $time, st, pid, rid);
                return;
            end
            want = expected_outcomes.pop_front();
            if (st !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            end
            if (pid !== want.provider_id)
            begin
                errors++;
                $display("%0t: provider_id expected %0d actual %0d",
                         $time, want.provider_id, pid);
            end
            if (rid !== want.requester_id)
            begin
                errors++;
                $display("%0t: requester_id expected %0d actual %0d",
                         $time, want.requester_id, rid);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [ACT_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ST_W-1:0]      m_tuser;

    pair_match_scoreboard sb = new;

    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    bit long_hold_req = 1'b0;

    fifo_pair_matcher_with_cancel dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // id[9:0], zero fill
        .s_tuser  (s_tuser),     // action[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // provider_id[9:0], requester_id[19:10]
        .m_tuser  (m_tuser)      // status[1:0]
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one command beat and hold it until taken. Valid stays high on return,
    // so back-to-back beats never lower and raise it in one step.
    task automatic send_command(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W-ID_W){1'b0}}, id};
        do @(posedge clk); while (!s_tready);
        sb.note_command(act, id);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.expected_outcomes.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    // Mostly a small id pool so cancels and duplicates hit live requesters.
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 7)
            return ID_W'($urandom_range(0, 15));
        return ID_W'($urandom_range(0, 1023));
    endfunction

    task automatic run_random(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_command(ACT_ADD_REQUESTER, pick_id());
            else if (r < 58)
                send_command(ACT_ADD_PROVIDER, pick_id());
            else if (r < 85)
                send_command(ACT_MATCH, pick_id());
            else
                send_command(ACT_CANCEL, pick_id());
        end
    endtask

    // Fill both queues past capacity, cancel a run of heads, then drain by matching.
    // A requester push dropped on a full queue must not revive a cancelled id.
    task automatic fill_and_drain();
        logic [ID_W-1:0] pushed[$];
        logic [ID_W-1:0] id;
        send_command(ACT_ADD_REQUESTER, 10'd777);
        for (int i = 0; i <= QUEUE_SLOTS; i++)
        begin
            id = ID_W'($urandom_range(0, 1023));
            pushed.push_back(id);
            send_command(ACT_ADD_REQUESTER, id);
        end
        send_command(ACT_CANCEL, 10'd777);
        send_command(ACT_ADD_REQUESTER, 10'd777);
        for (int i = 0; i < 20; i++)
            send_command(ACT_CANCEL, pushed[i]);
        for (int i = 0; i < QUEUE_SLOTS + 2; i++)
            send_command(ACT_ADD_PROVIDER, ID_W'($urandom_range(0, 1023)));
        for (int i = 0; i < QUEUE_SLOTS + 2; i++)
            send_command(ACT_MATCH, '0);
    endtask

    // Result side: sample at the rising edge.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_outcome(status_t'(m_tuser), m_tdata[ID_W-1:0], m_tdata[2*ID_W-1:ID_W]);

    // Receiver ready: random stall bursts, one long hold-off on request.
    initial
    begin : result_sink
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : command_source
        logic [ACT_W-1:0] dir_act [24];
        logic [ID_W-1:0]  dir_id  [24];
        // Directed opening: empty match, unknown cancel, extreme ids, skipped cancelled
        // head, duplicate ids sharing one waiting bit, cancel after match.
        dir_act = '{ACT_MATCH, ACT_CANCEL, ACT_ADD_REQUESTER, ACT_ADD_REQUESTER,
                    ACT_ADD_PROVIDER, ACT_ADD_PROVIDER, ACT_MATCH, ACT_MATCH,
                    ACT_MATCH, ACT_ADD_REQUESTER, ACT_ADD_REQUESTER, ACT_CANCEL,
                    ACT_ADD_PROVIDER, ACT_MATCH, ACT_ADD_REQUESTER, ACT_ADD_REQUESTER,
                    ACT_CANCEL, ACT_ADD_PROVIDER, ACT_MATCH, ACT_ADD_REQUESTER,
                    ACT_MATCH, ACT_CANCEL, ACT_ADD_PROVIDER, ACT_MATCH};
        dir_id  = '{10'd0, 10'd512, 10'd0, 10'd1023,
                    10'd1023, 10'd0, 10'd0, 10'd0,
                    10'd0, 10'd5, 10'd6, 10'd5,
                    10'd7, 10'd0, 10'd9, 10'd9,
                    10'd9, 10'd1, 10'd0, 10'h2AA,
                    10'd0, 10'd6, 10'h155, 10'd0};
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_ADD_REQUESTER;
        rst_n    = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 24; i++)
            send_command(dir_act[i], dir_id[i]);

        fill_and_drain();
        run_random(200);

        // Stall the result side for a long stretch while the bench keeps offering commands.
        long_hold_req = 1'b1;
        run_random(100);

        drain_results();
        run_random(50);

        // Last part at full rate on both sides.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(100);

        drain_results();
        repeat (100) @(negedge clk);
        if (sb.errors == 0 && sb.expected_outcomes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: fifo_pair_matcher_with_cancel.f
hw/rtl/fpm_pkg.sv
hw/rtl/fpm_ram.sv
hw/rtl/fpm_idx.sv
hw/rtl/fpm_seq.sv
hw/rtl/fifo_pair_matcher_with_cancel.sv
test/tb.sv
